// ===== rtl/core/cle_pkg.sv =====
// Types and codes shared by the core launch echo handshake block.
package cle_pkg;

    // Action codes of an input item
    localparam logic [2:0] ACT_BEGIN       = 3'd0;
    localparam logic [2:0] ACT_ECHO        = 3'd1;
    localparam logic [2:0] ACT_WR_TIMEOUT  = 3'd2;
    localparam logic [2:0] ACT_RD_TIMEOUT  = 3'd3;
    localparam logic [2:0] ACT_SERVICED    = 3'd4;
    localparam logic [2:0] ACT_SVC_TIMEOUT = 3'd5;

    // Status codes of a result item
    localparam logic [2:0] ST_AWAIT    = 3'd0;
    localparam logic [2:0] ST_LAUNCHED = 3'd1;
    localparam logic [2:0] ST_FAILED   = 3'd2;
    localparam logic [2:0] ST_REFUSED  = 3'd3;
    localparam logic [2:0] ST_REPORT   = 3'd4;

    // Failure phase codes
    localparam logic [1:0] PH_NONE       = 2'd0;
    localparam logic [1:0] PH_WR_TIMEOUT = 2'd1;
    localparam logic [1:0] PH_RD_TIMEOUT = 2'd2;
    localparam logic [1:0] PH_RESTARTS   = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] REG_VECTOR_TABLE = 3'd0;
    localparam logic [2:0] REG_STACK_TOP    = 3'd1;
    localparam logic [2:0] REG_ENTRY        = 3'd2;
    localparam logic [2:0] REG_MAX_RESTARTS = 3'd3;
    localparam logic [2:0] REG_ATTEMPT_CAP  = 3'd4;

    localparam logic [3:0] MAX_RESTARTS_RST = 4'd4;
    localparam logic [7:0] ATTEMPT_CAP_RST  = 8'd8;
    localparam logic [7:0] STREAK_MAX       = 8'hFF;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] echo_word;
    } t_in_item;

    typedef struct packed {
        logic        send_valid;
        logic [31:0] send_word;
        logic        flush_before_send;
        logic [2:0]  status;
        logic [1:0]  fail_phase;
        logic [2:0]  fail_index;
        logic        gave_up;
        logic [7:0]  streak_count;
    } t_out_item;

    typedef struct packed {
        logic [31:0] vector_table_address;
        logic [31:0] stack_top_address;
        logic [31:0] entry_address;
        logic [3:0]  max_restarts;
        logic [7:0]  attempt_cap;
    } t_cfg;

    typedef struct packed {
        logic [2:0] seq_index;
        logic [3:0] restart_count;
        logic       in_handshake;
        logic [7:0] failure_streak;
        logic       give_up_latch;
    } t_state;

endpackage

// ===== rtl/core/cle_cfg.sv =====
// Configuration register file of the core launch echo handshake block.
module cle_cfg
    import cle_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_wr_en,
    input  logic [2:0]  i_wr_index,
    input  logic [31:0] i_wr_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            unique case (i_wr_index)
                REG_VECTOR_TABLE: n_cfg.vector_table_address = i_wr_data;
                REG_STACK_TOP:    n_cfg.stack_top_address    = i_wr_data;
                REG_ENTRY:        n_cfg.entry_address        = i_wr_data;
                REG_MAX_RESTARTS: n_cfg.max_restarts         = i_wr_data[3:0];
                REG_ATTEMPT_CAP:  n_cfg.attempt_cap          = i_wr_data[7:0];
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.vector_table_address <= '0;
            r_cfg.stack_top_address    <= '0;
            r_cfg.entry_address        <= '0;
            r_cfg.max_restarts         <= MAX_RESTARTS_RST;
            r_cfg.attempt_cap          <= ATTEMPT_CAP_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/cle_step.sv =====
// Per-event next-state and result logic of the launch echo handshake.
module cle_step
    import cle_pkg::*;
#(
    parameter int SEQ_LENGTH = 6
) (
    input  t_in_item  i_item,
    input  t_state    i_state,
    input  t_cfg      i_cfg,
    output t_state    o_state,
    output t_out_item o_result
);

    localparam logic [3:0] LastIdx = 4'(SEQ_LENGTH - 1);
    localparam logic [3:0] SeqLen  = 4'(SEQ_LENGTH);

    function automatic logic [31:0] word_at(input logic [2:0] idx, input t_cfg cfg);
        logic [3:0] ix;
        ix = {1'b0, idx};
        if (ix == LastIdx)             return cfg.entry_address;
        if (ix + 4'd1 == LastIdx)      return cfg.stack_top_address;
        if (ix + 4'd2 == LastIdx)      return cfg.vector_table_address;
        if (ix + 4'd3 == LastIdx)      return 32'd1;
        return 32'd0;
    endfunction

    logic [31:0] cur_word;
    logic [31:0] emit_word;
    logic [3:0]  nxt_idx;
    logic        emit;
    logic [2:0]  emit_idx;
    logic        fail;
    logic [1:0]  fail_ph;
    logic        count_fail;
    logic [7:0]  streak_inc;

    assign cur_word   = word_at(i_state.seq_index, i_cfg);
    assign nxt_idx    = {1'b0, i_state.seq_index} + 4'd1;
    assign emit_word  = word_at(emit_idx, i_cfg);
    assign streak_inc = (i_state.failure_streak < STREAK_MAX) ?
                        i_state.failure_streak + 8'd1 : i_state.failure_streak;

    always_comb begin
        o_state    = i_state;
        o_result   = '0;
        emit       = 1'b0;
        emit_idx   = '0;
        fail       = 1'b0;
        fail_ph    = PH_NONE;
        count_fail = 1'b0;

        unique case (i_item.action)
            ACT_BEGIN: begin
                if (i_state.give_up_latch) begin
                    o_result.status = ST_REFUSED;
                end else begin
                    o_state.in_handshake  = 1'b1;
                    o_state.seq_index     = '0;
                    o_state.restart_count = '0;
                    emit                  = 1'b1;
                end
            end
            ACT_ECHO: begin
                if (i_state.in_handshake) begin
                    if (i_item.echo_word == cur_word) begin
                        if (nxt_idx >= SeqLen) begin
                            o_state.in_handshake  = 1'b0;
                            o_state.seq_index     = '0;
                            o_state.restart_count = '0;
                            o_result.status       = ST_LAUNCHED;
                        end else begin
                            o_state.seq_index = nxt_idx[2:0];
                            emit              = 1'b1;
                            emit_idx          = nxt_idx[2:0];
                        end
                    end else if (i_state.restart_count >= i_cfg.max_restarts) begin
                        fail    = 1'b1;
                        fail_ph = PH_RESTARTS;
                    end else begin
                        // wrong echo: start the sequence over
                        o_state.restart_count = i_state.restart_count + 4'd1;
                        o_state.seq_index     = '0;
                        emit                  = 1'b1;
                    end
                end
            end
            ACT_WR_TIMEOUT: begin
                if (i_state.in_handshake) begin
                    fail    = 1'b1;
                    fail_ph = PH_WR_TIMEOUT;
                end
            end
            ACT_RD_TIMEOUT: begin
                if (i_state.in_handshake) begin
                    fail    = 1'b1;
                    fail_ph = PH_RD_TIMEOUT;
                end
            end
            ACT_SERVICED: begin
                o_state.failure_streak = '0;
                o_result.status        = ST_REPORT;
            end
            ACT_SVC_TIMEOUT: begin
                count_fail      = 1'b1;
                o_result.status = ST_REPORT;
            end
            default: ;  // ignore unused action codes
        endcase

        if (emit) begin
            o_result.send_valid        = 1'b1;
            o_result.send_word         = emit_word;
            o_result.flush_before_send = (emit_word == 32'd0);
            o_result.status            = ST_AWAIT;
        end

        if (fail) begin
            o_result.status       = ST_FAILED;
            o_result.fail_phase   = fail_ph;
            o_result.fail_index   = i_state.seq_index;
            o_state.in_handshake  = 1'b0;
            o_state.seq_index     = '0;
            o_state.restart_count = '0;
            count_fail            = 1'b1;
        end

        if (count_fail) begin
            o_state.failure_streak = streak_inc;
            if (streak_inc >= i_cfg.attempt_cap) begin
                o_state.give_up_latch = 1'b1;
            end
        end

        o_result.gave_up      = o_state.give_up_latch;
        o_result.streak_count = o_state.failure_streak;
    end

endmodule

// ===== rtl/core/core_launch_echo_handshake.sv =====
// Top level of the core launch echo handshake initiator.
// Each input item is an event of the launch handshake (begin, echo, timeouts, service
// reports); each accepted event yields exactly one result item carrying the next word to
// send, the status, any failure phase and index, and the failure streak and give-up flag.
// An event is captured in an input register and resolved from there into the result
// register once that register is empty or being drained, so one event is taken every cycle
// while the output is not stalled. Handshake state updates as the
// event moves into the result register. Configuration registers are written through a
// separate channel that is always ready, and are to be written only while the block is idle.
module core_launch_echo_handshake
    import cle_pkg::*;
#(
    parameter int SEQ_LENGTH = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    t_cfg      cfg;
    t_state    r_state;
    t_state    n_state;
    t_out_item step_result;

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    logic      move;
    logic      in_xfer;

    assign o_cfg_ready = 1'b1;

    cle_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    cle_step #(
        .SEQ_LENGTH (SEQ_LENGTH)
    ) u_step (
        .i_item   (r_in),
        .i_state  (r_state),
        .i_cfg    (cfg),
        .o_state  (n_state),
        .o_result (step_result)
    );

    // advance when the result register is empty or being drained
    assign move       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !move;
    assign in_xfer    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (move) begin
                r_in_valid <= 1'b0;
            end
            if (move) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in <= i_in;
        end
        if (move) begin
            r_out <= step_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_state.in_handshake |-> (r_state.seq_index == '0 && r_state.restart_count == '0))
        else $error("idle handshake state not cleared");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_state.seq_index} < 4'(SEQ_LENGTH))
        else $error("sequence index out of range");

    a_latch_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.give_up_latch |=> r_state.give_up_latch)
        else $error("give-up flag cleared without reset");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_out_valid && i_out_stall))
        else $error("input stalled while result register can take a transfer");

    a_fail_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.status != ST_FAILED) |-> o_out.fail_phase == PH_NONE)
        else $error("failure phase reported without failure");

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the core launch echo handshake initiator.
`timescale 1ns / 100ps

module tb;
    import cle_pkg::*;

    localparam int SEQ_LEN = 6;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic [2:0] ACT_UNUSED_LO = 3'd6;
    localparam logic [2:0] ACT_UNUSED_HI = 3'd7;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    t_in_item    in_item;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out_item   out_item;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    // Predicted configuration and handshake state
    logic [31:0] cfg_vector       = '0;
    logic [31:0] cfg_stack        = '0;
    logic [31:0] cfg_entry        = '0;
    logic [3:0]  cfg_max_restarts = MAX_RESTARTS_RST;
    logic [7:0]  cfg_attempt_cap  = ATTEMPT_CAP_RST;
    logic [2:0]  seq_idx          = '0;
    logic [3:0]  restarts_used    = '0;
    logic        hs_active        = 1'b0;
    logic [7:0]  fail_streak      = '0;
    logic        gave_up_flag     = 1'b0;

    t_out_item pending_launch_results[$];
    int errors = 0;
    int sent_events = 0;
    int cycles = 0;
    int hold_cycles = 0;
    logic calm = 1'b0;

    core_launch_echo_handshake #(.SEQ_LENGTH(SEQ_LEN)) uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver: a forced hold-off wins over random stalls
    always @(posedge clk) begin
        if (hold_cycles > 0) begin
            out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else begin
            out_stall <= !calm && ($urandom_range(0, 99) < 9);
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    function automatic logic [31:0] seq_word(input logic [2:0] idx);
        if (idx == SEQ_LEN - 1) return cfg_entry;
        if (idx == SEQ_LEN - 2) return cfg_stack;
        if (idx == SEQ_LEN - 3) return cfg_vector;
        if (idx == SEQ_LEN - 4) return 32'd1;
        return 32'd0;
    endfunction

    function automatic t_out_item send_result(input logic [2:0] idx);
        t_out_item r;
        r = '0;
        r.send_valid = 1'b1;
        r.send_word = seq_word(idx);
        r.flush_before_send = (r.send_word == 32'd0);
        r.status = ST_AWAIT;
        return r;
    endfunction

    function automatic logic streak_headroom();
        return int'(fail_streak) + 4 < int'(cfg_attempt_cap);
    endfunction

    task automatic count_failure();
        if (fail_streak != STREAK_MAX) fail_streak++;
        if (fail_streak >= cfg_attempt_cap) gave_up_flag = 1'b1;
    endtask

    task automatic fail_launch(inout t_out_item r, input logic [1:0] phase);
        r.status = ST_FAILED;
        r.fail_phase = phase;
        r.fail_index = seq_idx;
        hs_active = 1'b0;
        seq_idx = '0;
        restarts_used = '0;
        count_failure();
    endtask

    task automatic predict_launch_event(input t_in_item ev);
        t_out_item r;
        r = '0;
        case (ev.action)
            ACT_BEGIN: begin
                if (gave_up_flag) begin
                    r.status = ST_REFUSED;
                end else begin
                    hs_active = 1'b1;
                    seq_idx = '0;
                    restarts_used = '0;
                    r = send_result(seq_idx);
                end
            end
            ACT_ECHO: begin
                if (hs_active) begin
                    if (ev.echo_word == seq_word(seq_idx)) begin
                        if (seq_idx == SEQ_LEN - 1) begin
                            hs_active = 1'b0;
                            seq_idx = '0;
                            restarts_used = '0;
                            r.status = ST_LAUNCHED;
                        end else begin
                            seq_idx++;
                            r = send_result(seq_idx);
                        end
                    end else if (restarts_used >= cfg_max_restarts) begin
                        fail_launch(r, PH_RESTARTS);
                    end else begin
                        restarts_used++;
                        seq_idx = '0;
                        r = send_result(seq_idx);
                    end
                end
            end
            ACT_WR_TIMEOUT: if (hs_active) fail_launch(r, PH_WR_TIMEOUT);
            ACT_RD_TIMEOUT: if (hs_active) fail_launch(r, PH_RD_TIMEOUT);
            ACT_SERVICED: begin
                fail_streak = '0;
                r.status = ST_REPORT;
            end
            ACT_SVC_TIMEOUT: begin
                count_failure();
                r.status = ST_REPORT;
            end
            default: ;
        endcase
        r.gave_up = gave_up_flag;
        r.streak_count = fail_streak;
        pending_launch_results.push_back(r);
    endtask

    always @(posedge clk) begin : check_results
        t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_launch_results.size() == 0) begin
                report_mismatch("result with no event", 32'(out_item.status), '0);
            end else begin
                want = pending_launch_results.pop_front();
                if (out_item.send_valid !== want.send_valid)
                    report_mismatch("send_valid", 32'(out_item.send_valid),
                                    32'(want.send_valid));
                if (out_item.send_word !== want.send_word)
                    report_mismatch("send_word", out_item.send_word, want.send_word);
                if (out_item.flush_before_send !== want.flush_before_send)
                    report_mismatch("flush_before_send", 32'(out_item.flush_before_send),
                                    32'(want.flush_before_send));
                if (out_item.status !== want.status)
                    report_mismatch("status", 32'(out_item.status), 32'(want.status));
                if (out_item.fail_phase !== want.fail_phase)
                    report_mismatch("fail_phase", 32'(out_item.fail_phase),
                                    32'(want.fail_phase));
                if (out_item.fail_index !== want.fail_index)
                    report_mismatch("fail_index", 32'(out_item.fail_index),
                                    32'(want.fail_index));
                if (out_item.gave_up !== want.gave_up)
                    report_mismatch("gave_up", 32'(out_item.gave_up), 32'(want.gave_up));
                if (out_item.streak_count !== want.streak_count)
                    report_mismatch("streak_count", 32'(out_item.streak_count),
                                    32'(want.streak_count));
            end
        end
    end

    // Returns right after the transfer edge with valid still high
    task automatic send_event(input logic [2:0] act, input logic [31:0] echo);
        t_in_item ev;
        ev.action = act;
        ev.echo_word = echo;
        while (!calm && $urandom_range(0, 99) < 9) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= ev;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_launch_event(ev);
        sent_events++;
    endtask

    task automatic wait_results_done();
        in_valid <= 1'b0;
        while (pending_launch_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            REG_VECTOR_TABLE: cfg_vector = data;
            REG_STACK_TOP:    cfg_stack = data;
            REG_ENTRY:        cfg_entry = data;
            REG_MAX_RESTARTS: cfg_max_restarts = data[3:0];
            REG_ATTEMPT_CAP:  cfg_attempt_cap = data[7:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Upper bits of the narrow registers carry junk that must be dropped
    task automatic load_launch_config(input logic [31:0] vec, input logic [31:0] stk,
                                      input logic [31:0] entry, input logic [3:0] restarts,
                                      input logic [7:0] cap);
        write_reg(REG_VECTOR_TABLE, vec);
        write_reg(REG_STACK_TOP, stk);
        write_reg(REG_ENTRY, entry);
        write_reg(REG_MAX_RESTARTS, {28'($urandom), restarts});
        write_reg(REG_ATTEMPT_CAP, {24'($urandom), cap});
    endtask

    // One launch from begin until the handshake ends, mostly correct echoes
    task automatic run_launch();
        int pick;
        logic [31:0] want;
        send_event(ACT_BEGIN, $urandom);
        while (hs_active) begin
            want = seq_word(seq_idx);
            pick = $urandom_range(0, 999);
            if (pick < 850)
                send_event(ACT_ECHO, want);
            else if (pick < 900)
                send_event(ACT_ECHO, want ^ (32'd1 << $urandom_range(0, 31)));
            else if (pick < 930)
                send_event(ACT_ECHO, $urandom);
            else if (pick < 945)
                send_event(ACT_WR_TIMEOUT, $urandom);
            else if (pick < 960)
                send_event(ACT_RD_TIMEOUT, $urandom);
            else if (pick < 970)
                send_event(ACT_BEGIN, $urandom);
            else if (pick < 980 || !streak_headroom())
                send_event(ACT_SERVICED, $urandom);
            else if (pick < 990)
                send_event(ACT_SVC_TIMEOUT, $urandom);
            else
                send_event(3'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI)), $urandom);
        end
    endtask

    task automatic test_directed_events();
        load_launch_config(32'hFFFF_FFFF, 32'h0, 32'h8000_0001, 4'd4, 8'd8);
        for (int r = REG_ATTEMPT_CAP + 1; r < 8; r++) write_reg(3'(r), $urandom);
        // events while idle are ignored
        send_event(ACT_ECHO, 32'h0);
        send_event(ACT_WR_TIMEOUT, 32'hFFFF_FFFF);
        send_event(ACT_RD_TIMEOUT, 32'h0);
        send_event(ACT_UNUSED_LO, 32'h0);
        send_event(ACT_UNUSED_HI, 32'hFFFF_FFFF);
        // clean launch
        send_event(ACT_BEGIN, 32'h0);
        for (int i = 0; i < SEQ_LEN; i++) send_event(ACT_ECHO, seq_word(3'(i)));
        // wrong echo, begin during a handshake, write timeout at word 0
        send_event(ACT_BEGIN, 32'h0);
        send_event(ACT_ECHO, 32'h0);
        send_event(ACT_ECHO, 32'hFFFF_FFFF);
        send_event(ACT_BEGIN, 32'h0);
        send_event(ACT_WR_TIMEOUT, 32'h0);
        // report during a handshake, then read timeout at word 2
        send_event(ACT_BEGIN, 32'h0);
        send_event(ACT_ECHO, 32'h0);
        send_event(ACT_ECHO, 32'h0);
        send_event(ACT_SERVICED, 32'h0);
        send_event(ACT_RD_TIMEOUT, 32'h0);
        send_event(ACT_SVC_TIMEOUT, 32'h0);
        send_event(ACT_SERVICED, 32'h0);
        wait_results_done();
    endtask

    task automatic test_random_launches();
        int goal;
        logic [2:0] act;
        for (int phase = 0; phase < 8; phase++) begin
            wait_results_done();
            case (phase)
                0: load_launch_config('1, '1, '1, 4'd15, 8'd255);
                1: load_launch_config('0, '0, '0, 4'd0, 8'd16);
                default: load_launch_config($urandom, $urandom, $urandom,
                                            4'($urandom_range(0, 15)),
                                            8'($urandom_range(16, 255)));
            endcase
            if ($urandom_range(0, 1) == 1) send_event(ACT_SERVICED, $urandom);
            calm = (phase == 3);
            goal = sent_events + 195;
            while (sent_events < goal) begin
                if (fail_streak >= 8) send_event(ACT_SERVICED, $urandom);
                if ($urandom_range(0, 9) == 0) begin
                    act = 3'($urandom_range(ACT_ECHO, ACT_UNUSED_HI));
                    if (act == ACT_SVC_TIMEOUT && !streak_headroom()) act = ACT_SERVICED;
                    send_event(act, $urandom);
                end
                run_launch();
            end
            calm = 1'b0;
        end
        wait_results_done();
    endtask

    // Hold the receiver off while the sender keeps offering, so the block fills up
    task automatic test_backpressure();
        int goal;
        if (fail_streak >= 8) send_event(ACT_SERVICED, $urandom);
        calm = 1'b1;
        hold_cycles = 60;
        goal = sent_events + 40;
        while (sent_events < goal) run_launch();
        calm = 1'b0;
        wait_results_done();
    endtask

    // A zero cap latches on the first failure; the latch is sticky, so this runs last
    task automatic test_give_up_latch();
        write_reg(REG_ATTEMPT_CAP, {24'($urandom), 8'd0});
        send_event(ACT_SERVICED, $urandom);
        send_event(ACT_BEGIN, $urandom);
        send_event(ACT_ECHO, seq_word(3'd0));
        send_event(ACT_SVC_TIMEOUT, $urandom);
        for (int i = 1; i < SEQ_LEN; i++) send_event(ACT_ECHO, seq_word(3'(i)));
        send_event(ACT_BEGIN, $urandom);
        send_event(ACT_ECHO, $urandom);
        // drive the streak into saturation
        repeat (260) send_event(ACT_SVC_TIMEOUT, $urandom);
        send_event(ACT_SERVICED, $urandom);
        send_event(ACT_BEGIN, $urandom);
        wait_results_done();
    endtask

    initial begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_item <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_events();
        test_random_launches();
        test_backpressure();
        test_give_up_latch();
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
